/* sv/hashed_node_router_defines.svh */
// Assertion macros for the hashed node router.
// Used by the top level; expects clk_i and rst_ni in scope where expanded.
`ifndef HASHED_NODE_ROUTER_DEFINES_SVH
`define HASHED_NODE_ROUTER_DEFINES_SVH

// Whenever ante holds, cons holds in the same cycle.
`define HNR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons holds in the following cycle.
`define HNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hnr_pkg.sv */
// Shared constants, types and helpers for the hashed node router.
// No dependencies; the other design files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hnr_pkg;

  // Table size and derived widths.
  localparam int NODE_SLOTS = 16;
  localparam int IDX_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
  localparam int OUT_IDX_W  = 4;

  // Field widths.
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int HASH_W     = 32;
  localparam int HASH_BIT_W = $clog2(HASH_W);
  localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;

  // Job queue between front and back.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = 2;
  localparam int CQ_CNT_W = 3;

  // Input command codes; code 3 is unused.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_KEY    = 2'd2
  } cmd_e;

  // Jobs handed to the back end.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ROUTE  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_NO_NODE = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [HASH_W-1:0] hash;
  } job_t;

  // Low bits of a table index, zero-extended when the index is narrow.
  function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/hnr_front.sv */
// Front end of the hashed node router: accepts input beats, folds key bytes
// into the running hash and hands add, remove and route jobs to the queue. Uses hnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnr_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [hnr_pkg::ADDR_W-1:0]  node_addr_i,
  input  wire logic [hnr_pkg::PORT_W-1:0]  node_port_i,
  input  wire logic [hnr_pkg::BYTE_W-1:0]  key_byte_i,
  input  wire logic                        key_last_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output hnr_pkg::job_t                    q_job_o
);

  logic [hnr_pkg::HASH_W-1:0] hash_q, hash_d;
  logic [hnr_pkg::HASH_W-1:0] hash_next;
  logic                       accept;
  logic                       is_key;

  // A beat is taken whenever the job queue has room.
  assign full_o = q_full_i;
  assign accept = push_i & ~q_full_i;
  assign is_key = (cmd_i == hnr_pkg::CMD_KEY);

  // Running hash: times 31 plus the byte; a zero byte leaves it alone.
  always_comb begin
    if (key_byte_i != '0) begin
      hash_next = hash_q * hnr_pkg::HASH_MULT
                + {{(hnr_pkg::HASH_W - hnr_pkg::BYTE_W){1'b0}}, key_byte_i};
    end else begin
      hash_next = hash_q;
    end
  end

  // The hash restarts after the last byte of a key.
  always_comb begin
    hash_d = hash_q;
    if (accept && is_key) begin
      hash_d = key_last_i ? '0 : hash_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  // Classify the beat into a job; mid-key bytes and the unused code make none.
  always_comb begin
    q_push_o      = 1'b0;
    q_job_o.op    = hnr_pkg::OP_ADD;
    q_job_o.addr  = node_addr_i;
    q_job_o.port  = node_port_i;
    q_job_o.hash  = hash_next;
    case (cmd_i)
      hnr_pkg::CMD_ADD: begin
        q_push_o   = accept;
        q_job_o.op = hnr_pkg::OP_ADD;
      end
      hnr_pkg::CMD_REMOVE: begin
        q_push_o   = accept;
        q_job_o.op = hnr_pkg::OP_REMOVE;
      end
      hnr_pkg::CMD_KEY: begin
        q_push_o   = accept & key_last_i;
        q_job_o.op = hnr_pkg::OP_ROUTE;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/hnr_cmd_q.sv */
// Short job queue between the front and back ends of the hashed node router.
// Holds hnr_pkg::job_t entries in a small circular buffer. Uses hnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnr_cmd_q (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hnr_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output hnr_pkg::job_t      job_o
);

  hnr_pkg::job_t                 slot_q [hnr_pkg::CQ_DEPTH];
  logic [hnr_pkg::CQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [hnr_pkg::CQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [hnr_pkg::CQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == hnr_pkg::CQ_CNT_W'(hnr_pkg::CQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

/* sv/hnr_back.sv */
// Back end of the hashed node router: node table, current pointer, entry
// scans, bit-serial modulo and the result register. Uses hnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnr_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_empty_i,
  input  wire hnr_pkg::job_t                  q_job_i,
  output logic                                q_pop_o,
  input  wire logic                           pop_i,
  output logic                                empty_o,
  output logic [1:0]                          status_o,
  output logic [hnr_pkg::OUT_IDX_W-1:0]       node_index_o,
  output logic [hnr_pkg::OUT_IDX_W-1:0]       current_node_o,
  output logic                                current_valid_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIND   = 6'b000010,
    S_UNLINK = 6'b000100,
    S_DIV    = 6'b001000,
    S_WALK   = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  localparam int IW = hnr_pkg::IDX_W;
  localparam int CW = hnr_pkg::CNT_W;

  state_e                          state_q, state_d;
  hnr_pkg::job_t                   job_q, job_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [hnr_pkg::NODE_SLOTS-1:0]  act_q, act_d;
  logic [CW-1:0]                   act_cnt_q, act_cnt_d;
  logic [IW-1:0]                   cur_idx_q, cur_idx_d;
  logic                            cur_vld_q, cur_vld_d;
  logic [CW-1:0]                   scan_q, scan_d;
  logic                            cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]                   cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]                   rem_q, rem_d;
  logic [hnr_pkg::HASH_BIT_W-1:0]  div_bits_q, div_bits_d;
  logic [CW-1:0]                   seen_q, seen_d;
  hnr_pkg::status_e                res_status_q, res_status_d;
  logic [IW-1:0]                   res_idx_q, res_idx_d;

  // Result register.
  logic                            out_vld_q, out_vld_d;
  hnr_pkg::status_e                out_status_q;
  logic [hnr_pkg::OUT_IDX_W-1:0]   out_idx_q;
  logic [hnr_pkg::OUT_IDX_W-1:0]   out_cur_q;
  logic                            out_cur_vld_q;
  logic                            out_load;

  // Node table storage and its registered read port.
  logic [hnr_pkg::ADDR_W-1:0]      mem_addr [hnr_pkg::NODE_SLOTS];
  logic [hnr_pkg::PORT_W-1:0]      mem_port [hnr_pkg::NODE_SLOTS];
  logic [hnr_pkg::ADDR_W-1:0]      rd_addr_q;
  logic [hnr_pkg::PORT_W-1:0]      rd_port_q;
  logic                            mem_we;

  logic [IW-1:0]                   scan_idx;
  logic [IW-1:0]                   cnt_idx;
  logic                            scan_more;
  logic                            hit;
  logic                            find_done;
  logic                            div_bit;
  logic [CW:0]                     trial;
  logic [CW:0]                     trial_sub;

  assign scan_idx  = scan_q[IW-1:0];
  assign cnt_idx   = cnt_q[IW-1:0];
  assign scan_more = (scan_q < cnt_q);
  assign hit       = cmp_vld_q && (rd_addr_q == job_q.addr) && (rd_port_q == job_q.port);
  assign find_done = hit || (!scan_more && !cmp_vld_q);

  // One remainder step per cycle, most significant hash bit first.
  assign div_bit   = job_q.hash[hnr_pkg::HASH_W-1];
  assign trial     = {rem_q, div_bit};
  assign trial_sub = trial - {1'b0, act_cnt_q};

  assign out_load  = (state_q == S_RESP) && (!out_vld_q || pop_i);

  // Job sequencer.
  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    cnt_d        = cnt_q;
    act_d        = act_q;
    act_cnt_d    = act_cnt_q;
    cur_idx_d    = cur_idx_q;
    cur_vld_d    = cur_vld_q;
    scan_d       = scan_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    rem_d        = rem_q;
    div_bits_d   = div_bits_q;
    seen_d       = seen_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    q_pop_o      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o      = 1'b1;
          job_d        = q_job_i;
          scan_d       = '0;
          res_status_d = hnr_pkg::ST_OK;
          res_idx_d    = '0;
          case (q_job_i.op)
            hnr_pkg::OP_ADD: begin
              // A full table rejects every add, known node or not.
              if (cnt_q == CW'(hnr_pkg::NODE_SLOTS)) begin
                res_status_d = hnr_pkg::ST_MISS;
                state_d      = S_RESP;
              end else begin
                state_d = S_FIND;
              end
            end
            hnr_pkg::OP_REMOVE: begin
              state_d = S_FIND;
            end
            hnr_pkg::OP_ROUTE: begin
              if (act_cnt_q == '0) begin
                res_status_d = hnr_pkg::ST_NO_NODE;
                state_d      = S_RESP;
              end else begin
                rem_d      = '0;
                div_bits_d = '0;
                state_d    = S_DIV;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_FIND: begin
        // Issue one table read per cycle; compare it the cycle after.
        if (scan_more) begin
          scan_d    = scan_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_idx;
        end
        if (find_done) begin
          cmp_vld_d = 1'b0;
          state_d   = S_RESP;
          if (job_q.op == hnr_pkg::OP_ADD) begin
            if (hit) begin
              act_d[cmp_idx_q] = 1'b1;
              if (!act_q[cmp_idx_q]) begin
                act_cnt_d = act_cnt_q + 1'b1;
              end
            end else begin
              // Append; the first entry ever becomes the current node.
              mem_we           = 1'b1;
              act_d[cnt_idx]   = 1'b1;
              act_cnt_d        = act_cnt_q + 1'b1;
              cnt_d            = cnt_q + 1'b1;
              if (cnt_q == '0) begin
                cur_idx_d = '0;
                cur_vld_d = 1'b1;
              end
            end
          end else begin
            if (hit) begin
              act_d[cmp_idx_q] = 1'b0;
              if (act_q[cmp_idx_q]) begin
                act_cnt_d = act_cnt_q - 1'b1;
              end
              // Removing the current node moves it to the first active entry.
              if (cur_vld_q && (cur_idx_q == cmp_idx_q)) begin
                cur_vld_d = 1'b0;
                cur_idx_d = '0;
                scan_d    = '0;
                state_d   = S_UNLINK;
              end
            end else begin
              res_status_d = hnr_pkg::ST_MISS;
            end
          end
        end
      end

      S_UNLINK: begin
        if (scan_more) begin
          if (act_q[scan_idx]) begin
            cur_idx_d = scan_idx;
            cur_vld_d = 1'b1;
            state_d   = S_RESP;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else begin
          state_d = S_RESP;
        end
      end

      S_DIV: begin
        if (trial >= {1'b0, act_cnt_q}) begin
          rem_d = trial_sub[CW-1:0];
        end else begin
          rem_d = trial[CW-1:0];
        end
        job_d.hash = job_q.hash << 1;
        div_bits_d = div_bits_q + 1'b1;
        if (div_bits_q == hnr_pkg::HASH_BIT_W'(hnr_pkg::HASH_W - 1)) begin
          scan_d  = '0;
          seen_d  = '0;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        // Count active entries until the ordinal given by the remainder.
        if (scan_more) begin
          scan_d = scan_q + 1'b1;
          if (act_q[scan_idx]) begin
            if (seen_q == rem_q) begin
              res_idx_d = scan_idx;
              state_d   = S_RESP;
            end else begin
              seen_d = seen_q + 1'b1;
            end
          end
        end else begin
          res_status_d = hnr_pkg::ST_NO_NODE;
          res_idx_d    = '0;
          state_d      = S_RESP;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      act_q     <= '0;
      act_cnt_q <= '0;
      cur_idx_q <= '0;
      cur_vld_q <= 1'b0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      act_q     <= act_d;
      act_cnt_q <= act_cnt_d;
      cur_idx_q <= cur_idx_d;
      cur_vld_q <= cur_vld_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Job payload and scratch registers.
  always_ff @(posedge clk_i) begin
    job_q        <= job_d;
    cmp_idx_q    <= cmp_idx_d;
    rem_q        <= rem_d;
    div_bits_q   <= div_bits_d;
    seen_q       <= seen_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
  end

  // Table memory: one write port at the append slot, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_addr[cnt_idx] <= job_q.addr;
      mem_port[cnt_idx] <= job_q.port;
    end
    rd_addr_q <= mem_addr[scan_idx];
    rd_port_q <= mem_port[scan_idx];
  end

  // Result register: loads when empty or when the waiting beat leaves.
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_idx_q     <= hnr_pkg::out_index(res_idx_q);
      out_cur_q     <= cur_vld_q ? hnr_pkg::out_index(cur_idx_q) : '0;
      out_cur_vld_q <= cur_vld_q;
    end
  end

  assign empty_o         = ~out_vld_q;
  assign status_o        = out_status_q;
  assign node_index_o    = out_idx_q;
  assign current_node_o  = out_cur_q;
  assign current_valid_o = out_cur_vld_q;

endmodule

`default_nettype wire

/* sv/hashed_node_router.sv */
// Top level of the hashed node router: front end, job queue and back end.
// Depends on hnr_pkg, hnr_front, hnr_cmd_q, hnr_back and the assertion macros.
//
//   Channel  Handshake          Beat payload
//   -------  -----------------  ------------------------------------------------
//   input    push / full        cmd_i, node_addr_i, node_port_i, key_byte_i,
//                               key_last_i
//   result   pop / empty        status_o, node_index_o, current_node_o,
//                               current_valid_o
//
// The front end takes one beat per cycle while the four-deep job queue has room;
// key bytes that do not end a key never reach the queue.
// An add or remove scans the table entries in order until a hit or the end of
// the table; removing the current node then scans for the first active entry.
// A route runs a bit-serial modulo over all 32 hash bits, then walks the active
// flags to the chosen entry; a full-table add or a route with no active node
// goes straight to the result. A job waits in its last state while the result
// beat is unread.
// Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_node_router_defines.svh"

module hashed_node_router (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     cmd_i,
  input  wire logic [hnr_pkg::ADDR_W-1:0]     node_addr_i,
  input  wire logic [hnr_pkg::PORT_W-1:0]     node_port_i,
  input  wire logic [hnr_pkg::BYTE_W-1:0]     key_byte_i,
  input  wire logic                           key_last_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [1:0]                          status_o,
  output logic [hnr_pkg::OUT_IDX_W-1:0]       node_index_o,
  output logic [hnr_pkg::OUT_IDX_W-1:0]       current_node_o,
  output logic                                current_valid_o
);

  logic          cq_push;
  logic          cq_full;
  logic          cq_pop;
  logic          cq_empty;
  hnr_pkg::job_t cq_job_in;
  hnr_pkg::job_t cq_job_out;

  // Front end: hashing and job classification.
  hnr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_i),
    .node_addr_i (node_addr_i),
    .node_port_i (node_port_i),
    .key_byte_i  (key_byte_i),
    .key_last_i  (key_last_i),
    .q_full_i    (cq_full),
    .q_push_o    (cq_push),
    .q_job_o     (cq_job_in)
  );

  // Job queue decoupling the two ends.
  hnr_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .job_i   (cq_job_in),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .job_o   (cq_job_out)
  );

  // Back end: node table and routing.
  hnr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (cq_empty),
    .q_job_i         (cq_job_out),
    .q_pop_o         (cq_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .status_o        (status_o),
    .node_index_o    (node_index_o),
    .current_node_o  (current_node_o),
    .current_valid_o (current_valid_o)
  );

  // The front end only hands over a job when the queue has room.
  `HNR_ASSERT_IMPL(a_push_has_room, cq_push, !cq_full, "job pushed into a full queue")
  // A key byte that does not end the key never creates a job.
  `HNR_ASSERT_IMPL(a_mid_key_no_job,
                   push && !full && (cmd_i == hnr_pkg::CMD_KEY) && !key_last_i,
                   !cq_push, "mid-key byte produced a job")
  // The back end only takes a job that is there.
  `HNR_ASSERT_IMPL(a_pop_has_job, cq_pop, !cq_empty, "job taken from an empty queue")
  // A taken job leaves the queue with room for the next one.
  `HNR_ASSERT_NEXT(a_pop_frees_slot, cq_pop && !cq_push, !cq_full,
                   "queue still full after a pop")

endmodule

`default_nettype wire
